// ===== hdl/dda_pkg.sv =====
// Package for the DDA line rasterizer: constants, controller types and command/status structs.
`default_nettype none

package dda_pkg;

    // Frame and coordinate geometry
    localparam int FRAME_SIZE = 64;
    localparam int COORD_W    = 6;
    localparam int COLOR_W    = 32;
    localparam int FRAC_BITS  = 16;

    // Accumulator holds integer and fraction part of the minor coordinate
    localparam int ACC_W      = COORD_W + FRAC_BITS;
    // Slope magnitude never exceeds one, so the quotient has one integer bit
    localparam int QUOT_W     = FRAC_BITS + 1;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(FRAME_SIZE - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [COLOR_W-1:0] t_color;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture a new segment and do the setup
        logic div_step;   // run one quotient bit of the slope division
        logic div_first;  // first division step, no remainder shift
        logic emit;       // send the current pixel and advance along the line
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic zero_len;   // segment has no extent along the major axis
        logic at_last;    // current pixel is the final one
        logic out_free;   // output register can take a pixel this cycle
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hdl/dda_datapath.sv =====
// Datapath of the DDA line rasterizer: segment setup, slope divider, accumulator, output register.
`default_nettype none

module dda_datapath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dda_pkg::t_dp_cmd     i_cmd,
    output dda_pkg::t_dp_status       o_status,
    input  wire dda_pkg::t_coord      i_start_x,
    input  wire dda_pkg::t_coord      i_start_y,
    input  wire dda_pkg::t_coord      i_end_x,
    input  wire dda_pkg::t_coord      i_end_y,
    input  wire dda_pkg::t_color      i_pixel_color,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output dda_pkg::t_coord           o_pixel_x,
    output dda_pkg::t_coord           o_pixel_y,
    output dda_pkg::t_color           o_out_color,
    output logic                      o_last_pixel
);
    import dda_pkg::*;

    // Segment registers
    t_coord              r_major;
    t_coord              r_major_end;
    t_coord              r_mag;
    t_coord              r_dmaj;
    logic                r_neg;
    logic                r_steep;
    t_color              r_color;
    logic [ACC_W-1:0]    r_acc;
    logic [COORD_W-1:0]  r_rem;
    logic [QUOT_W-1:0]   r_quot;

    // Output register
    logic                r_out_valid;
    t_coord              r_px;
    t_coord              r_py;
    t_color              r_out_color;
    logic                r_last;

    // Setup signals
    t_coord              ax_c, ay_c, bx_c, by_c;
    t_coord              adx, ady;
    logic                steep;
    t_coord              maj0, min0, maj1, min1;
    t_coord              maj_lo, min_lo, maj_hi, min_hi;

    // Division and stepping signals
    logic [COORD_W:0]    div_trial;
    logic                div_ge;
    logic [COORD_W:0]    div_diff;
    logic [ACC_W-1:0]    slope;
    t_coord              minor;

    // Saturate coordinates to the frame
    always_comb begin
        ax_c = (i_start_x > MAX_COORD) ? MAX_COORD : i_start_x;
        ay_c = (i_start_y > MAX_COORD) ? MAX_COORD : i_start_y;
        bx_c = (i_end_x   > MAX_COORD) ? MAX_COORD : i_end_x;
        by_c = (i_end_y   > MAX_COORD) ? MAX_COORD : i_end_y;
    end

    // Pick the major axis and order the endpoints along it
    always_comb begin
        adx   = (ax_c > bx_c) ? (ax_c - bx_c) : (bx_c - ax_c);
        ady   = (ay_c > by_c) ? (ay_c - by_c) : (by_c - ay_c);
        steep = (adx < ady);
        maj0  = steep ? ay_c : ax_c;
        min0  = steep ? ax_c : ay_c;
        maj1  = steep ? by_c : bx_c;
        min1  = steep ? bx_c : by_c;
        if (maj0 > maj1) begin
            maj_lo = maj1;
            min_lo = min1;
            maj_hi = maj0;
            min_hi = min0;
        end else begin
            maj_lo = maj0;
            min_lo = min0;
            maj_hi = maj1;
            min_hi = min1;
        end
    end

    // One restoring division step; the remainder stays below the divisor
    always_comb begin
        div_trial = i_cmd.div_first ? {1'b0, r_mag} : {r_rem, 1'b0};
        div_ge    = (div_trial >= {1'b0, r_dmaj});
        div_diff  = div_trial - {1'b0, r_dmaj};
    end

    // Signed slope in accumulator width, and the current minor coordinate
    always_comb begin
        slope = r_neg ? (ACC_W'(0) - ACC_W'(r_quot)) : ACC_W'(r_quot);
        minor = r_acc[ACC_W-1:FRAC_BITS];
    end

    // Segment state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_steep     <= steep;
            r_major     <= maj_lo;
            r_major_end <= maj_hi;
            r_dmaj      <= maj_hi - maj_lo;
            r_neg       <= (min_hi < min_lo);
            r_mag       <= (min_hi < min_lo) ? (min_lo - min_hi) : (min_hi - min_lo);
            r_acc       <= {min_lo, FRAC_BITS'(0)};
            r_color     <= i_pixel_color;
            r_quot      <= '0;
            r_rem       <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= div_ge ? div_diff[COORD_W-1:0] : div_trial[COORD_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], div_ge};
        end else if (i_cmd.emit) begin
            r_major <= r_major + COORD_W'(1);
            r_acc   <= r_acc + slope;
        end
    end

    // Output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; swap axes back for steep segments
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_px        <= r_steep ? minor : r_major;
            r_py        <= r_steep ? r_major : minor;
            r_out_color <= r_color;
            r_last      <= (r_major == r_major_end);
        end
    end

    always_comb begin
        o_status.zero_len = (r_dmaj == '0);
        o_status.at_last  = (r_major == r_major_end);
        o_status.out_free = !r_out_valid || !i_stall;
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_out_color  = r_out_color;
    assign o_last_pixel = r_last;

endmodule

`default_nettype wire

// ===== hdl/dda_ctrl.sv =====
// Controller of the DDA line rasterizer: sequences setup, slope division and pixel emission.
`default_nettype none

module dda_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire dda_pkg::t_dp_status  i_status,
    output dda_pkg::t_dp_cmd          o_cmd
);
    import dda_pkg::*;

    t_state                r_state, n_state;
    logic [DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;

    // State and step counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        n_div_cnt       = r_div_cnt;
        o_cmd.load      = 1'b0;
        o_cmd.div_step  = 1'b0;
        o_cmd.div_first = 1'b0;
        o_cmd.emit      = 1'b0;
        o_stall         = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_div_cnt  = '0;
                    n_state    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                // zero-length segment keeps a slope of zero
                if (i_status.zero_len) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.div_step  = 1'b1;
                    o_cmd.div_first = (r_div_cnt == '0);
                    n_div_cnt       = r_div_cnt + DIV_CNT_W'(1);
                    if (r_div_cnt == DIV_LAST_STEP) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.at_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/dda_line_rasterizer_unit.sv =====
// Top level of the DDA line rasterizer: controller and datapath.
//
// Input channel (i_valid / o_stall) takes one line segment per item: two
// endpoints and a color word. Coordinates beyond the frame are saturated to
// the last row or column. Output channel (o_valid / i_stall) gives one pixel
// per step along the major axis, with o_last_pixel high on the final one.
// Per segment: the accepting cycle loads and sets up the segment, then a
// restoring division forms the slope (one quotient bit per cycle), then
// pixels follow at one pixel per cycle while i_stall is low. A zero-length
// segment skips the division and gives its single pixel straight away.
// One segment is in work at a time; o_stall is high from acceptance until
// the last pixel has moved into the output register, so the next segment is
// taken while that pixel still waits to be read.
// When the receiver holds i_stall high, the output register holds its pixel
// and emission pauses. Synchronous reset clears the controller and output
// valid flag; no pixel is pending afterwards.
`default_nettype none

module dda_line_rasterizer_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire dda_pkg::t_coord   i_start_x,
    input  wire dda_pkg::t_coord   i_start_y,
    input  wire dda_pkg::t_coord   i_end_x,
    input  wire dda_pkg::t_coord   i_end_y,
    input  wire dda_pkg::t_color   i_pixel_color,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output dda_pkg::t_coord        o_pixel_x,
    output dda_pkg::t_coord        o_pixel_y,
    output dda_pkg::t_color        o_out_color,
    output logic                   o_last_pixel
);
    import dda_pkg::*;

    t_dp_cmd     cmd;
    t_dp_status  status;

    dda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dda_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_pixel_color (i_pixel_color),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_out_color   (o_out_color),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

`default_nettype wire
